[hw/rtl/rrt_pkg.sv]
// ----------------------------------------------------------------------------
// RR interval tracker package
// Shared default depth and codes for the RMSSD tracker.
// ----------------------------------------------------------------------------
`default_nettype none
package rrt_pkg;
    localparam int HISTORY_DEPTH_DEF = 256;

    localparam logic [1:0] CMD_BEAT  = 2'd0;
    localparam logic [1:0] CMD_CLEAR = 2'd1;
    localparam logic [1:0] CMD_LATCH = 2'd2;

    localparam logic [1:0] ST_KEPT     = 2'd0;
    localparam logic [1:0] ST_RANGE    = 2'd1;
    localparam logic [1:0] ST_ARTIFACT = 2'd2;
    localparam logic [1:0] ST_DONE     = 2'd3;

    localparam logic [2:0] REG_LOW  = 3'd0;
    localparam logic [2:0] REG_HIGH = 3'd1;
    localparam logic [2:0] REG_ART  = 3'd2;
    localparam logic [2:0] REG_MIN  = 3'd3;
    localparam logic [2:0] REG_WIN  = 3'd4;
    localparam logic [2:0] REG_REC  = 3'd5;
endpackage
`default_nettype wire

[hw/rtl/rr_interval_rmssd_tracker.sv]
// ----------------------------------------------------------------------------
// RR interval RMSSD tracker
// Beat interval filtering, sliding interval history and RMSSD evaluation.
// ----------------------------------------------------------------------------
// Each input item is a beat event (with a millisecond time stamp) or a command
// (clear history, latch baseline). Every item produces exactly one result item.
// The interval history lives in a simple dual-port synchronous memory used as a
// circular buffer. After each item the block re-reads the whole window from the
// memory, one entry per cycle, accumulating squared successive differences,
// then runs a 40-step divide, a 20-step square root and a 21-step divide for
// the recovery percent; a kept beat also runs a 20-step divide for the rate.
// The memory walk and the bit-serial divider and root set how long an item
// takes from acceptance to its result; rejected beats and items for which
// RMSSD is not valid take less. A new item is accepted while the previous
// result still waits in the output register.
`default_nettype none
module rr_interval_rmssd_tracker
    import rrt_pkg::*;
#(
    parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // tdata: beat_time_ms[31:0]
    input  wire logic [31:0] s_axis_tdata,
    // tuser: command[1:0]
    input  wire logic [1:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // tdata: interval_ms[15:0], rate_bpm_q4[27:16], rmssd_q4[41:28],
    // rmssd_valid[42], recovery_pct[52:43], recovered[53], zero fill to 56
    output logic [55:0]      m_axis_tdata,
    // tuser: status[1:0]
    output logic [1:0]       m_axis_tuser
);
    localparam int AW = $clog2(HISTORY_DEPTH);
    localparam int CW = $clog2(HISTORY_DEPTH + 1);
    localparam int MW = (CW > 9) ? CW : 9;
    localparam logic [CW-1:0] DEPTH_C = CW'(HISTORY_DEPTH);

    localparam logic [3:0] S_IDLE = 4'd0, S_PREV = 4'd1, S_PREVW = 4'd2,
        S_UPD = 4'd3, S_WSET = 4'd4, S_WALK = 4'd5, S_DIV = 4'd6,
        S_SQRT = 4'd7, S_RATE = 4'd8, S_PCT = 4'd9, S_OUT = 4'd10;

    logic [15:0] r_low, r_high;
    logic [6:0]  r_art, r_recp;
    logic [8:0]  r_min, r_win;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low <= 16'd450; r_high <= 16'd1300; r_art <= 7'd35;
            r_min <= 9'd10; r_win <= 9'd140; r_recp <= 7'd90;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_LOW:  r_low  <= i_cfg_data;
                REG_HIGH: r_high <= i_cfg_data;
                REG_ART:  r_art  <= i_cfg_data[6:0];
                REG_MIN:  r_min  <= i_cfg_data[8:0];
                REG_WIN:  r_win  <= i_cfg_data[8:0];
                REG_REC:  r_recp <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // History memory, circular: oldest at r_head, count entries.
    logic [15:0] mem [HISTORY_DEPTH];
    logic        mem_we;
    logic [AW-1:0] mem_wa, mem_ra;
    logic [15:0] mem_wd, r_rd;
    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_wa] <= mem_wd;
        r_rd <= mem[mem_ra];
    end

    logic [3:0]    r_state;
    logic [CW-1:0] r_cnt;
    logic [AW-1:0] r_head;
    logic [31:0]   r_last;
    logic [11:0]   r_rate;
    logic [13:0]   r_base;
    logic [1:0]    r_cmd, r_status;
    logic [15:0]   r_rr;
    logic [CW-1:0] r_n, r_k;
    logic [AW-1:0] r_addr;
    logic [15:0]   r_prev;
    logic [32:0]   r_sum;
    logic          r_valid;
    logic [5:0]    r_it;
    logic [39:0]   r_num, r_rem;  // divider: numerator shifts into remainder
    logic [19:0]   r_den;
    logic [39:0]   r_quo;
    logic [39:0]   r_x, r_res, r_bit;
    logic [13:0]   r_rq;
    logic          r_ovalid;
    logic [55:0]   r_odata;
    logic [1:0]    r_ostat;

    logic [CW-1:0] win_c, n_c;
    assign win_c = (MW'(r_win) > MW'(DEPTH_C)) ? DEPTH_C : CW'(r_win);
    assign n_c   = (r_cnt < win_c) ? r_cnt : win_c;

    function automatic logic [AW-1:0] wrap(input logic [CW:0] a);
        logic [CW:0] t;
        t = (a >= (CW+1)'(HISTORY_DEPTH)) ? a - (CW+1)'(HISTORY_DEPTH) : a;
        return t[AW-1:0];
    endfunction

    logic [16:0] dsub;
    logic [15:0] dabs;
    logic [31:0] sq;
    assign dsub = {1'b0, r_rd} - {1'b0, r_prev};
    assign dabs = dsub[16] ? 16'(~dsub + 17'd1) : dsub[15:0];
    assign sq   = 32'(dabs) * 32'(dabs);

    // Running sum including the pair that arrives this cycle, saturated.
    logic [32:0] n_sum;
    assign n_sum = (r_k < CW'(2)) ? r_sum :
                   ((r_sum + 33'(sq) > 33'hFFFFFFFF) ? 33'hFFFFFFFF : r_sum + 33'(sq));

    logic [40:0] trial;
    assign trial = {r_rem[38:0], r_num[39]} - {21'd0, r_den};
    logic [39:0] rb;
    assign rb = r_res + r_bit;

    logic [22:0] artl, artr;
    // The output register parts the two sides: input waits only for the engine.
    assign s_axis_tready = (r_state == S_IDLE);

    always_comb begin
        mem_we = 1'b0; mem_wa = '0; mem_wd = r_rr; mem_ra = r_addr;
        if (r_state == S_UPD && r_status == ST_KEPT) begin
            mem_we = 1'b1;
            mem_wa = (r_cnt < DEPTH_C) ? wrap({1'b0, CW'(r_head)} + {1'b0, r_cnt}) : r_head;
        end
        artl = 23'(r_rr > r_rd ? r_rr - r_rd : r_rd - r_rr) * 23'd100;
        artr = 23'(r_art) * 23'(r_rd);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_cnt <= '0; r_head <= '0; r_last <= '0;
            r_rate <= '0; r_base <= '0; r_ovalid <= 1'b0;
        end else begin
            if (m_axis_tready) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: if (s_axis_tvalid && s_axis_tready) begin
                    r_cmd <= s_axis_tuser; r_rr <= '0; r_status <= ST_DONE;
                    r_addr <= wrap({1'b0, CW'(r_head)} + {1'b0, r_cnt} - 1'b1);
                    if (s_axis_tuser == CMD_BEAT) begin
                        r_rr <= s_axis_tdata[15:0] - r_last[15:0];
                        r_last <= s_axis_tdata;
                        r_state <= S_PREV;
                    end else begin
                        if (s_axis_tuser == CMD_CLEAR) r_cnt <= '0;
                        r_state <= S_WSET;
                    end
                end
                S_PREV: begin
                    r_status <= (r_rr > r_low && r_rr < r_high) ? ST_KEPT : ST_RANGE;
                    r_state  <= S_PREVW;
                end
                S_PREVW: begin
                    if (r_status == ST_KEPT && r_cnt != '0 && artl > artr)
                        r_status <= ST_ARTIFACT;
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    if (r_status == ST_KEPT) begin
                        if (r_cnt < DEPTH_C) r_cnt <= r_cnt + 1'b1;
                        else r_head <= wrap({1'b0, CW'(r_head)} + 1'b1);
                        r_num <= 40'(20'd960000) << 20; r_den <= 20'(r_rr);
                        r_rem <= '0; r_quo <= '0; r_it <= 6'd20;
                        r_state <= S_RATE;
                    end else r_state <= S_WSET;
                end
                S_RATE: begin
                    if (r_it == 0) begin
                        r_rate <= (r_quo > 40'd4095) ? 12'd4095 : r_quo[11:0];
                        r_state <= S_WSET;
                    end else begin
                        if (!trial[40]) begin
                            r_rem <= trial[39:0]; r_quo <= {r_quo[38:0], 1'b1};
                        end else begin
                            r_rem <= {r_rem[38:0], r_num[39]}; r_quo <= {r_quo[38:0], 1'b0};
                        end
                        r_num <= {r_num[38:0], 1'b0}; r_it <= r_it - 1'b1;
                    end
                end
                S_WSET: begin
                    r_n <= n_c; r_sum <= '0; r_k <= '0;
                    r_valid <= !(MW'(r_cnt) < MW'(r_min) || n_c < CW'(2));
                    r_addr <= wrap({1'b0, CW'(r_head)} + {1'b0, r_cnt - n_c});
                    r_state <= S_WALK;
                end
                S_WALK: begin
                    // r_rd holds the entry read for index r_k-1.
                    if (!r_valid) begin
                        r_rq <= '0; r_state <= S_PCT; r_it <= '0;
                    end else begin
                        r_sum <= n_sum;
                        if (r_k != '0) r_prev <= r_rd;
                        if (r_k == r_n) begin
                            r_num <= {n_sum[31:0], 8'd0}; r_den <= 20'(r_n - 1'b1);
                            r_rem <= '0; r_quo <= '0; r_it <= 6'd40;
                            r_state <= S_DIV;
                        end else begin
                            r_addr <= wrap({1'b0, CW'(r_addr)} + 1'b1);
                            r_k <= r_k + 1'b1;
                        end
                    end
                end
                S_DIV: begin
                    if (r_it == 0) begin
                        r_x <= r_quo; r_res <= '0; r_bit <= 40'd1 << 38; r_state <= S_SQRT;
                    end else begin
                        if (!trial[40]) begin
                            r_rem <= trial[39:0]; r_quo <= {r_quo[38:0], 1'b1};
                        end else begin
                            r_rem <= {r_rem[38:0], r_num[39]}; r_quo <= {r_quo[38:0], 1'b0};
                        end
                        r_num <= {r_num[38:0], 1'b0}; r_it <= r_it - 1'b1;
                    end
                end
                S_SQRT: begin
                    if (r_bit == 0) begin
                        r_rq <= (r_res > 40'd16383) ? 14'd16383 : r_res[13:0];
                        r_state <= S_PCT; r_it <= '0;
                    end else begin
                        if (r_x >= rb) begin
                            r_x <= r_x - rb; r_res <= (r_res >> 1) + r_bit;
                        end else r_res <= r_res >> 1;
                        r_bit <= r_bit >> 2;
                    end
                end
                S_PCT: begin
                    if (r_it == 0) begin
                        if (r_cmd == CMD_LATCH) r_base <= r_valid ? r_rq : '0;
                        r_num <= 40'(21'(r_rq) * 21'd100) << 19;
                        r_rem <= '0; r_quo <= '0; r_it <= 6'd22;
                        r_den <= 20'((r_cmd == CMD_LATCH) ? (r_valid ? r_rq : 14'd0) : r_base);
                    end else if (r_it == 1) begin
                        r_state <= S_OUT;
                    end else begin
                        if (!trial[40]) begin
                            r_rem <= trial[39:0]; r_quo <= {r_quo[38:0], 1'b1};
                        end else begin
                            r_rem <= {r_rem[38:0], r_num[39]}; r_quo <= {r_quo[38:0], 1'b0};
                        end
                        r_num <= {r_num[38:0], 1'b0}; r_it <= r_it - 1'b1;
                    end
                end
                S_OUT: begin
                    // Wait here until the output register is free.
                    if (!r_ovalid || m_axis_tready) begin
                        r_ovalid <= 1'b1; r_ostat <= r_status;
                        r_odata <= {2'b00,
                            r_valid && (24'(r_rq) * 24'd100 >= 24'(r_recp) * 24'(r_base)),
                            (r_valid && r_base != 0) ?
                                ((r_quo > 40'd1023) ? 10'd1023 : r_quo[9:0]) : 10'd0,
                            r_valid, r_rq, r_rate, r_rr};
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_ostat;

    // Count never exceeds the memory depth.
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n) r_cnt <= DEPTH_C)
        else $error("history count overflow");
    // A stalled result item stays valid and unchanged.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !m_axis_tready) |=> (r_ovalid && $stable(r_odata)))
        else $error("result changed while stalled");
    // A clear leaves the history empty.
    a_clr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tuser == CMD_CLEAR) |=> r_cnt == '0)
        else $error("clear failed");
endmodule
`default_nettype wire

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// RR interval RMSSD tracker testbench
// Drives beat events and commands into the tracker through its input stream,
// predicts every result item with an independent model of the interval
// filter, sliding history and RMSSD arithmetic, and compares the output stream
// field by field. Phases run under several register settings and idle patterns.
// ----------------------------------------------------------------------------
`default_nettype none
module testbench;
    import rrt_pkg::*;

    localparam int DEPTH = HISTORY_DEPTH_DEF;
    // The command encoding leaves one value unused; the block must answer it
    // with a plain "command done" result.
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    // Longest item takes about the full window plus the divider and root steps.
    localparam int ITEM_CYCLES = 400;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] interval_ms;
        logic [11:0] rate;
        logic [13:0] rmssd;
        logic        valid;
        logic [9:0]  recovery_pct;
        logic        recovered;
    } tracker_result_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_index;
    logic [15:0] i_cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [55:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    rr_interval_rmssd_tracker dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    // Shadow copy of the registers and the tracker state.
    logic [15:0] low_ms, high_ms;
    logic [6:0]  art_pct, rec_pct;
    logic [8:0]  min_cnt, win_cnt;
    logic [15:0] rr_hist [DEPTH];
    int          hist_cnt;
    logic [31:0] last_beat;
    logic [11:0] cur_rate;
    logic [13:0] baseline;

    tracker_result_t pending_results[$];
    int errors;
    int send_idle_pct;
    int stall_pct;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #80_000_000;
        $display("Some tests failed");
        $finish;
    end

    // Integer square root, bit by bit from the top pair of bits down.
    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned root;
        longint unsigned one;
        root = 0;
        one = 64'd1 << 62;
        while (one > x) one >>= 2;
        while (one != 0) begin
            if (x >= root + one) begin
                x -= root + one;
                root = (root >> 1) + one;
            end else begin
                root >>= 1;
            end
            one >>= 2;
        end
        return root;
    endfunction

    // Applies one item to the shadow state and returns the result it causes.
    function automatic tracker_result_t track_item(logic [1:0] cmd, logic [31:0] t);
        tracker_result_t res;
        logic [15:0] rr;
        int unsigned prev, diff, rate_full, win, n, pct;
        longint unsigned sum, sq;
        int d;
        bit ok;
        res = '0;
        rr = '0;
        res.status = ST_DONE;
        if (cmd == CMD_BEAT) begin
            rr = t[15:0] - last_beat[15:0];
            last_beat = t;
            if (!(rr > low_ms && rr < high_ms)) begin
                res.status = ST_RANGE;
            end else begin
                res.status = ST_KEPT;
                if (hist_cnt > 0) begin
                    prev = rr_hist[hist_cnt-1];
                    diff = (rr > prev) ? rr - prev : prev - rr;
                    if (diff * 100 > art_pct * prev) res.status = ST_ARTIFACT;
                end
                if (res.status == ST_KEPT) begin
                    // A full history slides by one, losing its oldest interval.
                    if (hist_cnt < DEPTH) begin
                        rr_hist[hist_cnt] = rr;
                        hist_cnt++;
                    end else begin
                        for (int i = 0; i < DEPTH - 1; i++) rr_hist[i] = rr_hist[i+1];
                        rr_hist[DEPTH-1] = rr;
                    end
                    rate_full = 960000 / rr;
                    cur_rate = (rate_full > 4095) ? 12'd4095 : rate_full[11:0];
                end
            end
        end else if (cmd == CMD_CLEAR) begin
            hist_cnt = 0;
        end

        win = (win_cnt > DEPTH) ? DEPTH : win_cnt;
        n = (hist_cnt < win) ? hist_cnt : win;
        ok = (hist_cnt >= min_cnt) && (n >= 2);
        if (ok) begin
            sum = 0;
            for (int i = hist_cnt - n + 1; i < hist_cnt; i++) begin
                d = int'(rr_hist[i]) - int'(rr_hist[i-1]);
                if (d < 0) d = -d;
                sum += longint'(d) * longint'(d);
            end
            if (sum > 64'hFFFF_FFFF) sum = 64'hFFFF_FFFF;
            sq = int_sqrt((sum * 256) / (n - 1));
            res.rmssd = (sq > 16383) ? 14'd16383 : sq[13:0];
        end
        if (cmd == CMD_LATCH) baseline = ok ? res.rmssd : 14'd0;
        if (ok) begin
            if (baseline != 0) begin
                pct = (res.rmssd * 100) / baseline;
                res.recovery_pct = (pct > 1023) ? 10'd1023 : pct[9:0];
            end
            res.recovered = (res.rmssd * 100 >= rec_pct * baseline);
        end
        res.interval_ms = rr;
        res.rate = cur_rate;
        res.valid = ok;
        return res;
    endfunction

    task automatic check_field(string name, int unsigned exp_v, int unsigned act_v);
        if (exp_v != act_v) begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
            errors++;
        end
    endtask

    // Output side: random back-pressure and the comparison of every result.
    always @(posedge i_clk) begin
        tracker_result_t exp_r;
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                $error("result item arrived with no expectation waiting");
                errors++;
            end else begin
                exp_r = pending_results.pop_front();
                check_field("status", exp_r.status, m_axis_tuser);
                check_field("interval_ms", exp_r.interval_ms, m_axis_tdata[15:0]);
                check_field("rate_bpm_q4", exp_r.rate, m_axis_tdata[27:16]);
                check_field("rmssd_q4", exp_r.rmssd, m_axis_tdata[41:28]);
                check_field("rmssd_valid", exp_r.valid, m_axis_tdata[42]);
                check_field("recovery_pct", exp_r.recovery_pct, m_axis_tdata[52:43]);
                check_field("recovered", exp_r.recovered, m_axis_tdata[53]);
            end
        end
    end

    // Sends one item. The valid stays high between back-to-back items and is
    // only dropped when the sender decides to idle before the next one.
    task automatic send_item(logic [1:0] cmd, logic [31:0] t);
        if ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= t;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        pending_results.push_back(track_item(cmd, t));
    endtask

    task automatic send_beat_after(int unsigned iv);
        send_item(CMD_BEAT, last_beat + iv);
    endtask

    // Holds the input stream back until every expected result has come.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        case (idx)
            REG_LOW:  low_ms  = val;
            REG_HIGH: high_ms = val;
            REG_ART:  art_pct = val[6:0];
            REG_MIN:  min_cnt = val[8:0];
            REG_WIN:  win_cnt = val[8:0];
            REG_REC:  rec_pct = val[6:0];
            default: ;
        endcase
    endtask

    // Writes all six registers; only called with the block idle.
    task automatic set_config(int lo, int hi, int art, int mn, int win, int rec);
        drain();
        write_reg(REG_LOW, 16'(lo));
        write_reg(REG_HIGH, 16'(hi));
        write_reg(REG_ART, 16'(art));
        write_reg(REG_MIN, 16'(mn));
        write_reg(REG_WIN, 16'(win));
        write_reg(REG_REC, 16'(rec));
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Mostly plausible beats that tend to pass the filter, with some noise,
    // wild intervals and occasional commands mixed in.
    task automatic send_random_item();
        int unsigned r, base, delta, iv;
        r = $urandom_range(99);
        if (r < 3) begin
            send_item(CMD_CLEAR, $urandom);
        end else if (r < 6) begin
            send_item(CMD_LATCH, $urandom);
        end else if (r < 7) begin
            send_item(CMD_UNUSED, $urandom);
        end else if (r < 13) begin
            send_item(CMD_BEAT, $urandom);
        end else if (r < 19) begin
            send_beat_after($urandom_range(0, 65535));
        end else begin
            base = (hist_cnt > 0) ? rr_hist[hist_cnt-1] : $urandom_range(500, 1200);
            delta = base * art_pct / 100 + 2;
            iv = base + $urandom_range(0, 2 * delta) - delta;
            send_beat_after(iv & 16'hFFFF);
        end
    endtask

    // Directed: unused command, latch without history, limit edges, artifact
    // rejection, time stamp wrap, baseline latch and the clear command.
    task automatic test_directed();
        send_item(CMD_UNUSED, 32'h0);
        send_item(CMD_LATCH, 32'hFFFF_FFFF);
        send_beat_after(1000);
        send_beat_after(450);
        send_beat_after(1300);
        send_beat_after(999);
        send_beat_after(350);
        send_beat_after(600);
        send_item(CMD_BEAT, 32'hFFFF_FFF0);
        send_item(CMD_BEAT, 32'h0000_0300);
        send_beat_after(451);
        for (int i = 0; i < 9; i++) send_beat_after(800 + 30 * (i % 3));
        send_item(CMD_LATCH, 32'h0);
        send_beat_after(1000);
        send_beat_after(1299);
        send_item(CMD_CLEAR, 32'h0);
        send_beat_after(700);
    endtask

    // Register extremes: widest limits, huge swings that saturate the sum,
    // zero artifact tolerance and windows or minimums that forbid RMSSD.
    task automatic test_register_extremes();
        set_config(0, 65535, 127, 2, 2, 0);
        send_item(CMD_CLEAR, 0);
        for (int i = 0; i < 12; i++) send_beat_after((i % 2) ? 65000 : 30000);
        set_config(0, 65535, 100, 2, 256, 127);
        send_item(CMD_LATCH, 0);
        for (int i = 0; i < 12; i++) send_beat_after((i % 2) ? 1 : 2);
        send_item(CMD_LATCH, 0);
        for (int i = 0; i < 6; i++) send_beat_after((i % 2) ? 65534 : 32767);
        set_config(65535, 0, 0, 300, 511, 100);
        for (int i = 0; i < 4; i++) send_beat_after(1000);
        set_config(400, 1400, 0, 2, 1, 100);
        for (int i = 0; i < 4; i++) send_beat_after(800 + i % 2);
        drain();
        write_reg(REG_WIN, 16'd0);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        send_beat_after(800);
        set_config(400, 1400, 0, 256, 256, 50);
        for (int i = 0; i < 6; i++) send_beat_after(800);
    endtask

    // Fills and overruns the whole history with the widest window.
    task automatic test_full_history();
        set_config(300, 1500, 20, 256, 511, 80);
        send_item(CMD_CLEAR, 0);
        for (int i = 0; i < 300; i++) begin
            if (i == 270) send_item(CMD_LATCH, 0);
            else send_beat_after(900 + $urandom_range(0, 100));
        end
    endtask

    task automatic test_random_phase(int idle, int stall, int items);
        send_idle_pct = idle;
        stall_pct = stall;
        for (int c = 0; c < 3; c++) begin
            set_config($urandom_range(300, 600), $urandom_range(900, 1500),
                       $urandom_range(0, 100), $urandom_range(2, 20),
                       ($urandom_range(5) == 0) ? $urandom_range(100, 256)
                                                : $urandom_range(2, 40),
                       $urandom_range(0, 100));
            for (int i = 0; i < items; i++) send_random_item();
        end
    endtask

    initial begin
        errors = 0;
        send_idle_pct = 0;
        stall_pct = 0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        m_axis_tready = 1'b0;
        low_ms = 450; high_ms = 1300; art_pct = 35;
        min_cnt = 10; win_cnt = 140; rec_pct = 90;
        hist_cnt = 0; last_beat = '0; cur_rate = '0; baseline = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_register_extremes();
        test_full_history();
        test_random_phase(0, 0, 110);
        test_random_phase(79, 0, 110);
        test_random_phase(0, 79, 110);
        test_random_phase(25, 25, 110);

        drain();
        repeat (ITEM_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
`default_nettype wire
